// ===== rtl/qsm_pkg.sv =====
// Shared types, constants and helper functions for the quadrotor stabiliser mixer.
package qsm_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // Shared multiplier operand and result widths
   localparam int OP_A_W = WORD_WIDTH + 1;
   localparam int OP_B_W = FRAC_BITS + 2;
   localparam int PROD_W = OP_A_W + OP_B_W;
   localparam int MULQ_W = PROD_W - FRAC_BITS;

   // Intermediate sum widths
   localparam int ERR_W  = WORD_WIDTH + 2;
   localparam int BASE_W = WORD_WIDTH + 1;
   localparam int TERM_W = WORD_WIDTH + 2;
   localparam int SUM_W  = WORD_WIDTH + 5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_HOVER_THRUST    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALTITUDE_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTICAL_GAIN   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROLL_GAIN       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_GAIN      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALTITUDE_STEP   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_PUSH      = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_YAW_PUSH        = 3'd7;

   localparam logic [1:0] BIN_LOW  = 2'd0;
   localparam logic [1:0] BIN_HIGH = 2'd2;

   localparam logic [30:0]        HOVER_THRUST_RST    = 31'd4489216;
   localparam logic signed [31:0] ALTITUDE_OFFSET_RST = 32'sd39322;
   localparam logic [30:0]        VERTICAL_GAIN_RST   = 31'd196608;
   localparam logic [30:0]        ROLL_GAIN_RST       = 31'd3276800;
   localparam logic [30:0]        PITCH_GAIN_RST      = 31'd1966080;
   localparam logic [16:0]        ALTITUDE_STEP_RST   = 17'd328;
   localparam logic [30:0]        PITCH_PUSH_RST      = 31'd131072;
   localparam logic [30:0]        YAW_PUSH_RST        = 31'd85197;
   localparam logic signed [WORD_WIDTH-1:0] TARGET_RST = WORD_WIDTH'(1 << FRAC_BITS);

   localparam logic signed [OP_B_W-1:0] GIMBAL_ROLL_K =
      OP_B_W'((115 * (1 << FRAC_BITS) + 500) / 1000);
   localparam logic signed [OP_B_W-1:0] GIMBAL_PITCH_K =
      OP_B_W'(((1 << FRAC_BITS) + 5) / 10);

   localparam logic signed [ERR_W-1:0] UNIT_HI = ERR_W'(1 << FRAC_BITS);
   localparam logic signed [ERR_W-1:0] UNIT_LO = -UNIT_HI;

   localparam logic signed [SUM_W-1:0] WORD_MAX =
      {{(SUM_W - WORD_WIDTH + 1){1'b0}}, {(WORD_WIDTH - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] WORD_MIN = ~WORD_MAX;

   typedef struct packed {
      logic signed [31:0] roll_angle;
      logic signed [31:0] pitch_angle;
      logic signed [31:0] altitude_now;
      logic signed [31:0] roll_rate;
      logic signed [31:0] pitch_rate;
      logic [1:0]         forward_bin;
      logic [1:0]         turn_bin;
      logic [1:0]         climb_bin;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] front_left_speed;
      logic signed [31:0] front_right_speed;
      logic signed [31:0] rear_left_speed;
      logic signed [31:0] rear_right_speed;
      logic signed [31:0] gimbal_roll_position;
      logic signed [31:0] gimbal_pitch_position;
      logic signed [31:0] altitude_goal;
   } rsp_payload_type;

   // Terms handed from the sequencer to the mixer
   typedef struct packed {
      logic signed [BASE_W-1:0]     base;
      logic signed [TERM_W-1:0]     roll_term;
      logic signed [TERM_W-1:0]     pitch_term;
      logic signed [WORD_WIDTH-1:0] yaw_term;
      logic signed [MULQ_W-1:0]     gimbal_roll_prod;
      logic signed [MULQ_W-1:0]     gimbal_pitch_prod;
      logic signed [WORD_WIDTH-1:0] target;
   } mix_terms_type;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_ERR    = 10'b00_0000_0010,
      ST_SQ     = 10'b00_0000_0100,
      ST_CUBE   = 10'b00_0000_1000,
      ST_VERT   = 10'b00_0001_0000,
      ST_ROLL   = 10'b00_0010_0000,
      ST_PITCH  = 10'b00_0100_0000,
      ST_GROLL  = 10'b00_1000_0000,
      ST_GPITCH = 10'b01_0000_0000,
      ST_MIX    = 10'b10_0000_0000
   } state_type;

   // Clamp to the range minus one to plus one
   function automatic logic signed [OP_B_W-1:0] clamp_unit(input logic signed [ERR_W-1:0] v);
      logic signed [ERR_W-1:0] c;
      c = v;
      if (v > UNIT_HI) begin
         c = UNIT_HI;
      end else if (v < UNIT_LO) begin
         c = UNIT_LO;
      end
      return c[OP_B_W-1:0];
   endfunction

   // Saturate to the signed word range
   function automatic logic signed [WORD_WIDTH-1:0] sat_word(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] c;
      c = v;
      if (v > WORD_MAX) begin
         c = WORD_MAX;
      end else if (v < WORD_MIN) begin
         c = WORD_MIN;
      end
      return c[WORD_WIDTH-1:0];
   endfunction

endpackage

// ===== rtl/qsm_mul.sv =====
// Shared signed multiplier with registered product and fraction-bit floor shift.
module qsm_mul (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [qsm_pkg::OP_A_W-1:0]   op_a,
   input  logic signed [qsm_pkg::OP_B_W-1:0]   op_b,
   output logic signed [qsm_pkg::MULQ_W-1:0]   prod_q
);
   import qsm_pkg::*;

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // hold the product until the next issue
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // dropping the fraction bits of a two's complement value rounds toward minus infinity
   assign prod_q = prod_ff[PROD_W-1:FRAC_BITS];

endmodule

// ===== rtl/qsm_mix.sv =====
// Motor mixer and output saturation for the quadrotor stabiliser.
module qsm_mix (
   input  qsm_pkg::mix_terms_type   terms,
   output qsm_pkg::rsp_payload_type result
);
   import qsm_pkg::*;

   logic signed [SUM_W-1:0] base_x;
   logic signed [SUM_W-1:0] roll_x;
   logic signed [SUM_W-1:0] pitch_x;
   logic signed [SUM_W-1:0] yaw_x;
   logic signed [SUM_W-1:0] fl_sum;
   logic signed [SUM_W-1:0] fr_sum;
   logic signed [SUM_W-1:0] rl_sum;
   logic signed [SUM_W-1:0] rr_sum;
   logic signed [SUM_W-1:0] groll_x;
   logic signed [SUM_W-1:0] gpitch_x;

   assign base_x  = SUM_W'(terms.base);
   assign roll_x  = SUM_W'(terms.roll_term);
   assign pitch_x = SUM_W'(terms.pitch_term);
   assign yaw_x   = SUM_W'(terms.yaw_term);

   assign fl_sum = base_x - roll_x + pitch_x - yaw_x;
   // front right and rear left spin the other way
   assign fr_sum = -(base_x + roll_x + pitch_x + yaw_x);
   assign rl_sum = -(base_x - roll_x - pitch_x + yaw_x);
   assign rr_sum = base_x + roll_x - pitch_x - yaw_x;

   assign groll_x  = -SUM_W'(terms.gimbal_roll_prod);
   assign gpitch_x = -SUM_W'(terms.gimbal_pitch_prod);

   always_comb begin
      result.front_left_speed      = sat_word(fl_sum);
      result.front_right_speed     = sat_word(fr_sum);
      result.rear_left_speed       = sat_word(rl_sum);
      result.rear_right_speed      = sat_word(rr_sum);
      result.gimbal_roll_position  = sat_word(groll_x);
      result.gimbal_pitch_position = sat_word(gpitch_x);
      result.altitude_goal         = terms.target;
   end

endmodule

// ===== rtl/quadrotor_stabilizer_mixer.sv =====
// An accepted request runs eight sequencer steps and the mix before rsp_valid rises.
// A new request is taken only while the sequencer is idle, not while one is in flight or the
// mix waits on a stalled output; the seven products share the single 33x18 multiplier, three of them a dependent chain.
// A finished result waits in the output register; a new request is taken meanwhile.
// Reset (synchronous): target altitude 1.0, all settings to their defaults, no result held.
module quadrotor_stabilizer_mixer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  qsm_pkg::req_payload_type               req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output qsm_pkg::rsp_payload_type               rsp_data,
   input  logic                                   csr_we,
   input  logic [qsm_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [qsm_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import qsm_pkg::*;

   // settings
   logic [30:0]        hover_thrust_ff;
   logic signed [31:0] altitude_offset_ff;
   logic [30:0]        vertical_gain_ff;
   logic [30:0]        roll_gain_ff;
   logic [30:0]        pitch_gain_ff;
   logic [16:0]        altitude_step_ff;
   logic [30:0]        pitch_push_ff;
   logic [30:0]        yaw_push_ff;

   state_type state_ff, state_in;

   logic signed [WORD_WIDTH-1:0] target_ff, target_in;
   logic signed [WORD_WIDTH-1:0] altitude_ff;
   logic signed [WORD_WIDTH-1:0] roll_rate_ff;
   logic signed [WORD_WIDTH-1:0] pitch_rate_ff;
   logic signed [OP_B_W-1:0]     roll_clamp_ff;
   logic signed [OP_B_W-1:0]     pitch_clamp_ff;
   logic signed [BASE_W-1:0]     pitch_bias_ff, pitch_bias_in;
   logic signed [WORD_WIDTH-1:0] yaw_ff, yaw_in;
   logic signed [OP_B_W-1:0]     err_ff;
   logic signed [BASE_W-1:0]     base_ff;
   logic signed [TERM_W-1:0]     roll_term_ff;
   logic signed [TERM_W-1:0]     pitch_term_ff;
   logic signed [MULQ_W-1:0]     gimbal_roll_ff;

   logic                         rsp_valid_ff;
   rsp_payload_type              rsp_data_ff;

   logic                         req_take;
   logic                         rsp_load;
   logic                         mul_load;
   logic signed [OP_A_W-1:0]     op_a;
   logic signed [OP_B_W-1:0]     op_b;
   logic signed [MULQ_W-1:0]     mul_q;
   logic signed [WORD_WIDTH-1:0] push_pitch;
   logic signed [SUM_W-1:0]      target_up;
   logic signed [SUM_W-1:0]      target_down;
   logic signed [ERR_W-1:0]      err_full;
   mix_terms_type                mix_terms;
   rsp_payload_type              mix_result;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_MIX) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // settings write port
   always_ff @(posedge clock) begin
      if (reset) begin
         hover_thrust_ff    <= HOVER_THRUST_RST;
         altitude_offset_ff <= ALTITUDE_OFFSET_RST;
         vertical_gain_ff   <= VERTICAL_GAIN_RST;
         roll_gain_ff       <= ROLL_GAIN_RST;
         pitch_gain_ff      <= PITCH_GAIN_RST;
         altitude_step_ff   <= ALTITUDE_STEP_RST;
         pitch_push_ff      <= PITCH_PUSH_RST;
         yaw_push_ff        <= YAW_PUSH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HOVER_THRUST:    hover_thrust_ff    <= csr_wdata[30:0];
            CSR_ALTITUDE_OFFSET: altitude_offset_ff <= csr_wdata;
            CSR_VERTICAL_GAIN:   vertical_gain_ff   <= csr_wdata[30:0];
            CSR_ROLL_GAIN:       roll_gain_ff       <= csr_wdata[30:0];
            CSR_PITCH_GAIN:      pitch_gain_ff      <= csr_wdata[30:0];
            CSR_ALTITUDE_STEP:   altitude_step_ff   <= csr_wdata[16:0];
            CSR_PITCH_PUSH:      pitch_push_ff      <= csr_wdata[30:0];
            CSR_YAW_PUSH:        yaw_push_ff        <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // action bins: the first one that is not neutral acts
   assign target_up   = SUM_W'(target_ff) + $signed(SUM_W'(altitude_step_ff));
   assign target_down = SUM_W'(target_ff) - $signed(SUM_W'(altitude_step_ff));

   always_comb begin
      push_pitch = '0;
      yaw_in     = '0;
      target_in  = target_ff;
      if (req_data.forward_bin == BIN_HIGH) begin
         push_pitch = -$signed({1'b0, pitch_push_ff});
      end else if (req_data.forward_bin == BIN_LOW) begin
         push_pitch = $signed({1'b0, pitch_push_ff});
      end else if (req_data.turn_bin == BIN_HIGH) begin
         yaw_in = $signed({1'b0, yaw_push_ff});
      end else if (req_data.turn_bin == BIN_LOW) begin
         yaw_in = -$signed({1'b0, yaw_push_ff});
      end else if (req_data.climb_bin == BIN_HIGH) begin
         target_in = sat_word(target_up);
      end else if (req_data.climb_bin == BIN_LOW) begin
         target_in = sat_word(target_down);
      end
      pitch_bias_in = BASE_W'(req_data.pitch_rate) + BASE_W'(push_pitch);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RST;
      end else if (req_take) begin
         target_ff <= target_in;
      end
   end

   // latch the request
   always_ff @(posedge clock) begin
      if (req_take) begin
         altitude_ff    <= req_data.altitude_now;
         roll_rate_ff   <= req_data.roll_rate;
         pitch_rate_ff  <= req_data.pitch_rate;
         roll_clamp_ff  <= clamp_unit(ERR_W'(req_data.roll_angle));
         pitch_clamp_ff <= clamp_unit(ERR_W'(req_data.pitch_angle));
         pitch_bias_ff  <= pitch_bias_in;
         yaw_ff         <= yaw_in;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_take) state_in = ST_ERR;
         ST_ERR:    state_in = ST_SQ;
         ST_SQ:     state_in = ST_CUBE;
         ST_CUBE:   state_in = ST_VERT;
         ST_VERT:   state_in = ST_ROLL;
         ST_ROLL:   state_in = ST_PITCH;
         ST_PITCH:  state_in = ST_GROLL;
         ST_GROLL:  state_in = ST_GPITCH;
         ST_GPITCH: state_in = ST_MIX;
         ST_MIX:    if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_load = 1'b1;
      op_a     = '0;
      op_b     = '0;
      unique case (state_ff)
         ST_SQ: begin
            op_a = OP_A_W'(err_ff);
            op_b = err_ff;
         end
         ST_CUBE: begin
            op_a = mul_q[OP_A_W-1:0];
            op_b = err_ff;
         end
         ST_VERT: begin
            op_a = $signed({2'b00, vertical_gain_ff});
            op_b = mul_q[OP_B_W-1:0];
         end
         ST_ROLL: begin
            op_a = $signed({2'b00, roll_gain_ff});
            op_b = roll_clamp_ff;
         end
         ST_PITCH: begin
            op_a = $signed({2'b00, pitch_gain_ff});
            op_b = pitch_clamp_ff;
         end
         ST_GROLL: begin
            op_a = OP_A_W'(roll_rate_ff);
            op_b = GIMBAL_ROLL_K;
         end
         ST_GPITCH: begin
            op_a = OP_A_W'(pitch_rate_ff);
            op_b = GIMBAL_PITCH_K;
         end
         default: mul_load = 1'b0;
      endcase
   end

   qsm_mul u_mul (
      .clock  (clock),
      .load   (mul_load),
      .op_a   (op_a),
      .op_b   (op_b),
      .prod_q (mul_q)
   );

   assign err_full = ERR_W'(target_ff) - ERR_W'(altitude_ff) + ERR_W'(altitude_offset_ff);

   // register the clamped error, and each mix term in the state after its product issues
   always_ff @(posedge clock) begin
      if (state_ff == ST_ERR) begin
         err_ff <= clamp_unit(err_full);
      end
      if (state_ff == ST_ROLL) begin
         base_ff <= $signed({2'b00, hover_thrust_ff}) + mul_q[BASE_W-1:0];
      end
      if (state_ff == ST_PITCH) begin
         roll_term_ff <= mul_q[TERM_W-1:0] + TERM_W'(roll_rate_ff);
      end
      if (state_ff == ST_GROLL) begin
         pitch_term_ff <= mul_q[TERM_W-1:0] + TERM_W'(pitch_bias_ff);
      end
      if (state_ff == ST_GPITCH) begin
         gimbal_roll_ff <= mul_q;
      end
   end

   always_comb begin
      mix_terms.base              = base_ff;
      mix_terms.roll_term         = roll_term_ff;
      mix_terms.pitch_term        = pitch_term_ff;
      mix_terms.yaw_term          = yaw_ff;
      mix_terms.gimbal_roll_prod  = gimbal_roll_ff;
      mix_terms.gimbal_pitch_prod = mul_q;
      mix_terms.target            = target_ff;
   end

   qsm_mix u_mix (
      .terms  (mix_terms),
      .result (mix_result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= mix_result;
      end
   end

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_ERR))
      else $error("accepted request did not start the sequence");

   a_rsp_from_mix: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MIX))
      else $error("result appeared without the mix step");

   a_target_hold: assert property (@(posedge clock) disable iff (reset)
      !req_take |=> $stable(target_ff))
      else $error("target altitude changed without a request");
`endif

endmodule

// ===== dv/tb_quadrotor_stabilizer_mixer.sv =====
// Self-checking bench for the quadrotor stabiliser mixer: directed ticks, random ticks, altitude ramps.
module tb_quadrotor_stabilizer_mixer;

   localparam int     FRAC        = 16;
   localparam longint UNIT        = 64'sd65536;
   localparam longint WORD_HI     = 64'sd2147483647;
   localparam longint WORD_LO     = -WORD_HI - 1;
   localparam longint ROLL_CAM_K  = (115 * UNIT + 500) / 1000;
   localparam longint PITCH_CAM_K = (UNIT + 5) / 10;
   localparam int     FIELD_COUNT = 7;
   localparam int     QUIET_LIMIT = 1000;

   localparam logic [1:0] BIN_IDLE  = 2'd1;
   localparam logic [1:0] BIN_SPARE = 2'd3;

   typedef struct {
      qsm_pkg::req_payload_type stim;
      bit                       typed;
      qsm_pkg::rsp_payload_type golden;
   } script_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   qsm_pkg::req_payload_type            req_data;
   logic                                rsp_valid;
   logic                                rsp_stall;
   qsm_pkg::rsp_payload_type            rsp_data;
   logic                                csr_we;
   logic [qsm_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [qsm_pkg::CSR_DATA_W-1:0]      csr_wdata;

   // typed answer travelling alongside the request being offered
   logic                                golden_valid;
   qsm_pkg::rsp_payload_type            golden_tick;

   // predictor copy of the settings and the held altitude
   longint hover_q, offset_q, vgain_q, rgain_q, pgain_q, step_q, ppush_q, ypush_q;
   longint target_q;
   logic signed [31:0] target_mirror;

   qsm_pkg::rsp_payload_type due_commands[$];
   int             ticks_issued;
   int             ticks_returned;
   int             faults;
   int             quiet_cycles;
   int             sink_wait;
   logic           calm;
   script_row_type script[$];

   string field_names[FIELD_COUNT] = '{"front_left_speed", "front_right_speed",
      "rear_left_speed", "rear_right_speed", "gimbal_roll_position",
      "gimbal_pitch_position", "altitude_goal"};

   quadrotor_stabilizer_mixer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic signed [31:0] to_word(longint v);
      longint c;
      c = clip(v, WORD_LO, WORD_HI);
      return c[31:0];
   endfunction

   function automatic void apply_setting(logic [qsm_pkg::CSR_INDEX_W-1:0] idx,
                                         logic [31:0] v);
      case (idx)
         qsm_pkg::CSR_HOVER_THRUST:    hover_q  = longint'(v[30:0]);
         qsm_pkg::CSR_ALTITUDE_OFFSET: offset_q = longint'($signed(v));
         qsm_pkg::CSR_VERTICAL_GAIN:   vgain_q  = longint'(v[30:0]);
         qsm_pkg::CSR_ROLL_GAIN:       rgain_q  = longint'(v[30:0]);
         qsm_pkg::CSR_PITCH_GAIN:      pgain_q  = longint'(v[30:0]);
         qsm_pkg::CSR_ALTITUDE_STEP:   step_q   = longint'(v[16:0]);
         qsm_pkg::CSR_PITCH_PUSH:      ppush_q  = longint'(v[30:0]);
         qsm_pkg::CSR_YAW_PUSH:        ypush_q  = longint'(v[30:0]);
         default: ;
      endcase
   endfunction

   // One control tick: action bins, P terms, cubed altitude error, motor mix, gimbal positions
   function automatic qsm_pkg::rsp_payload_type mix_tick(qsm_pkg::req_payload_type t);
      longint push_p, push_y, r_term, p_term, err, sq, cube, lift, base;
      qsm_pkg::rsp_payload_type o;
      push_p = 0;
      push_y = 0;
      if (t.forward_bin == qsm_pkg::BIN_HIGH) begin
         push_p = -ppush_q;
      end else if (t.forward_bin == qsm_pkg::BIN_LOW) begin
         push_p = ppush_q;
      end else if (t.turn_bin == qsm_pkg::BIN_HIGH) begin
         push_y = ypush_q;
      end else if (t.turn_bin == qsm_pkg::BIN_LOW) begin
         push_y = -ypush_q;
      end else if (t.climb_bin == qsm_pkg::BIN_HIGH) begin
         target_q = clip(target_q + step_q, WORD_LO, WORD_HI);
      end else if (t.climb_bin == qsm_pkg::BIN_LOW) begin
         target_q = clip(target_q - step_q, WORD_LO, WORD_HI);
      end
      r_term = ((rgain_q * clip(t.roll_angle, -UNIT, UNIT)) >>> FRAC) + t.roll_rate;
      p_term = ((pgain_q * clip(t.pitch_angle, -UNIT, UNIT)) >>> FRAC) + t.pitch_rate
               + push_p;
      err    = clip(target_q - t.altitude_now + offset_q, -UNIT, UNIT);
      sq     = (err * err) >>> FRAC;
      cube   = (sq * err) >>> FRAC;
      lift   = (vgain_q * cube) >>> FRAC;
      base   = hover_q + lift;
      o.front_left_speed      = to_word(base - r_term + p_term - push_y);
      o.front_right_speed     = to_word(-(base + r_term + p_term + push_y));
      o.rear_left_speed       = to_word(-(base - r_term - p_term + push_y));
      o.rear_right_speed      = to_word(base + r_term - p_term - push_y);
      o.gimbal_roll_position  = to_word(-((ROLL_CAM_K * t.roll_rate) >>> FRAC));
      o.gimbal_pitch_position = to_word(-((PITCH_CAM_K * t.pitch_rate) >>> FRAC));
      o.altitude_goal         = target_q[31:0];
      return o;
   endfunction

   function automatic logic signed [31:0] pick_angle();
      longint v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: v = longint'($urandom_range(0, 3 * 65536)) - 3 * UNIT / 2;
         6, 7:             v = longint'($signed($urandom()));
         8:                v = $urandom_range(0, 1) ? WORD_HI : WORD_LO;
         default:          v = ($urandom_range(0, 1) ? UNIT : -UNIT)
                               + longint'($urandom_range(0, 2)) - 1;
      endcase
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] pick_rate();
      longint v;
      if ($urandom_range(0, 4) != 0) begin
         v = longint'($urandom_range(0, 8 * 65536)) - 4 * UNIT;
      end else begin
         v = longint'($signed($urandom()));
      end
      return v[31:0];
   endfunction

   function automatic logic [1:0] pick_bin();
      case ($urandom_range(0, 6))
         0:       return qsm_pkg::BIN_LOW;
         1:       return qsm_pkg::BIN_HIGH;
         2:       return BIN_SPARE;
         default: return BIN_IDLE;
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 3))
         0:       return '1;
         1:       return '0;
         default: return $urandom();
      endcase
   endfunction

   // Altitude mostly within 1.5 of the held target plus the offset so the cubic often stays out of its clamp
   function automatic qsm_pkg::req_payload_type make_tick();
      qsm_pkg::req_payload_type t;
      longint a;
      t.roll_angle  = pick_angle();
      t.pitch_angle = pick_angle();
      t.roll_rate   = pick_rate();
      t.pitch_rate  = pick_rate();
      if ($urandom_range(0, 9) < 7) begin
         a = longint'(target_mirror) + offset_q
             + longint'($urandom_range(0, 3 * 65536)) - 3 * UNIT / 2;
      end else begin
         a = longint'($signed($urandom()));
      end
      t.altitude_now = a[31:0];
      t.forward_bin  = pick_bin();
      t.turn_bin     = pick_bin();
      t.climb_bin    = pick_bin();
      return t;
   endfunction

   function automatic void add_row(qsm_pkg::req_payload_type s, bit typed,
                                   qsm_pkg::rsp_payload_type g);
      script_row_type r;
      r.stim   = s;
      r.typed  = typed;
      r.golden = g;
      script.push_back(r);
   endfunction

   // Offer one request and hold it until taken
   task automatic send_tick(qsm_pkg::req_payload_type t, bit typed,
                            qsm_pkg::rsp_payload_type g);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_data     <= t;
      golden_valid <= typed;
      golden_tick  <= g;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (ticks_returned != ticks_issued);
   endtask

   task automatic put(logic [qsm_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
   endtask

   task automatic program_settings(logic [31:0] hover, logic [31:0] offset,
                                   logic [31:0] vgain, logic [31:0] rgain,
                                   logic [31:0] pgain, logic [31:0] step,
                                   logic [31:0] ppush, logic [31:0] ypush);
      put(qsm_pkg::CSR_HOVER_THRUST, hover);
      put(qsm_pkg::CSR_ALTITUDE_OFFSET, offset);
      put(qsm_pkg::CSR_VERTICAL_GAIN, vgain);
      put(qsm_pkg::CSR_ROLL_GAIN, rgain);
      put(qsm_pkg::CSR_PITCH_GAIN, pgain);
      put(qsm_pkg::CSR_ALTITUDE_STEP, step);
      put(qsm_pkg::CSR_PITCH_PUSH, ppush);
      put(qsm_pkg::CSR_YAW_PUSH, ypush);
      csr_we <= 1'b0;
   endtask

   task automatic program_plausible(logic [31:0] step);
      program_settings(32'($urandom_range(0, 200 * 65536)),
                       32'($urandom_range(0, 4 * 65536)) - 32'(2 * 65536),
                       32'($urandom_range(0, 10 * 65536)),
                       32'($urandom_range(0, 100 * 65536)),
                       32'($urandom_range(0, 100 * 65536)),
                       step,
                       32'($urandom_range(0, 8 * 65536)),
                       32'($urandom_range(0, 8 * 65536)));
   endtask

   task automatic random_ticks(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            calm <= ($urandom_range(0, 3) == 0);
         end
         send_tick(make_tick(), 1'b0, '0);
      end
      settle();
   endtask

   // Step the held target the same way on every tick, the other bins neutral
   task automatic ramp_target(bit rising, int count);
      qsm_pkg::req_payload_type t;
      calm <= 1'b1;
      for (int n = 0; n < count; n++) begin
         t = make_tick();
         t.forward_bin = $urandom_range(0, 1) ? BIN_IDLE : BIN_SPARE;
         t.turn_bin    = $urandom_range(0, 1) ? BIN_IDLE : BIN_SPARE;
         t.climb_bin   = rising ? qsm_pkg::BIN_HIGH : qsm_pkg::BIN_LOW;
         send_tick(t, 1'b0, '0);
      end
      settle();
   endtask

   // Predict on every accepted request, check every accepted result
   always @(posedge clock) begin
      qsm_pkg::rsp_payload_type want;
      qsm_pkg::rsp_payload_type got;
      if (!reset) begin
         if (csr_we) begin
            apply_setting(csr_index, csr_wdata);
         end
         if (req_valid && !req_stall) begin
            want = mix_tick(req_data);
            if (golden_valid) begin
               want = golden_tick;
            end
            due_commands.push_back(want);
            ticks_issued  <= ticks_issued + 1;
            target_mirror <= target_q[31:0];
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            ticks_returned <= ticks_returned + 1;
            if (due_commands.size() == 0) begin
               faults++;
               $display("%0t: result with no request outstanding: %h", $time, got);
            end else begin
               want = due_commands.pop_front();
               for (int f = 0; f < FIELD_COUNT; f++) begin
                  if (got[32 * (FIELD_COUNT - f) - 1 -: 32]
                      !== want[32 * (FIELD_COUNT - f) - 1 -: 32]) begin
                     faults++;
                     $display("%0t: %s expected %0d, got %0d", $time, field_names[f],
                              $signed(want[32 * (FIELD_COUNT - f) - 1 -: 32]),
                              $signed(got[32 * (FIELD_COUNT - f) - 1 -: 32]));
                  end
               end
            end
         end
      end
   end

   // Receiver back-pressure: a fresh hold after every result taken
   always @(posedge clock) begin
      int w;
      if (reset) begin
         sink_wait <= 0;
         rsp_stall <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         w = calm ? 0 : $urandom_range(0, 9);
         sink_wait <= w;
         rsp_stall <= (w != 0);
      end else if (sink_wait != 0) begin
         sink_wait <= sink_wait - 1;
         rsp_stall <= (sink_wait > 1);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("quadrotor_stabilizer_mixer regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_we         = 1'b0;
      csr_index      = qsm_pkg::CSR_HOVER_THRUST;
      csr_wdata      = '0;
      golden_valid   = 1'b0;
      golden_tick    = '0;
      calm           = 1'b0;
      faults         = 0;
      quiet_cycles   = 0;
      ticks_issued   = 0;
      ticks_returned = 0;
      hover_q        = 137 * UNIT / 2;
      offset_q       = (6 * UNIT + 5) / 10;
      vgain_q        = 3 * UNIT;
      rgain_q        = 50 * UNIT;
      pgain_q        = 30 * UNIT;
      step_q         = (5 * UNIT + 500) / 1000;
      ppush_q        = 2 * UNIT;
      ypush_q        = (13 * UNIT + 5) / 10;
      target_q       = UNIT;
      target_mirror  = 32'sd65536;

      // Defaults after reset; altitude 105186 or 104858 cancels the offset exactly
      add_row('{0, 0, 0, 0, 0, BIN_IDLE, BIN_IDLE, BIN_IDLE}, 1'b1,
              '{4685824, -4685824, -4685824, 4685824, 0, 0, 65536});
      add_row('{0, 0, 105186, 0, 0, BIN_IDLE, BIN_IDLE, qsm_pkg::BIN_HIGH}, 1'b1,
              '{4489216, -4489216, -4489216, 4489216, 0, 0, 65864});
      add_row('{0, 0, 105186, 0, 0, qsm_pkg::BIN_HIGH, BIN_IDLE, qsm_pkg::BIN_HIGH}, 1'b1,
              '{4358144, -4358144, -4620288, 4620288, 0, 0, 65864});
      add_row('{0, 0, 105186, 0, 0, BIN_IDLE, qsm_pkg::BIN_HIGH, BIN_IDLE}, 1'b1,
              '{4404019, -4574413, -4574413, 4404019, 0, 0, 65864});
      add_row('{0, 0, 105186, 0, 0, BIN_SPARE, qsm_pkg::BIN_LOW, BIN_IDLE}, 1'b1,
              '{4574413, -4404019, -4404019, 4574413, 0, 0, 65864});
      add_row('{0, 0, 105186, 0, 0, qsm_pkg::BIN_LOW, BIN_IDLE, BIN_IDLE}, 1'b1,
              '{4620288, -4620288, -4358144, 4358144, 0, 0, 65864});
      add_row('{0, 0, 104858, 0, 0, BIN_IDLE, BIN_IDLE, qsm_pkg::BIN_LOW}, 1'b1,
              '{4489216, -4489216, -4489216, 4489216, 0, 0, 65536});
      add_row('{0, 0, 104858, 0, 0, BIN_SPARE, BIN_SPARE, BIN_SPARE}, 1'b1,
              '{4489216, -4489216, -4489216, 4489216, 0, 0, 65536});
      add_row('{0, 0, 105186, 0, 0, BIN_IDLE, BIN_SPARE, qsm_pkg::BIN_HIGH}, 1'b1,
              '{4489216, -4489216, -4489216, 4489216, 0, 0, 65864});
      add_row('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh8000_0000, BIN_IDLE, BIN_IDLE, BIN_IDLE}, 1'b0, '0);
      add_row('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                32'sh7FFF_FFFF, BIN_IDLE, BIN_IDLE, BIN_IDLE}, 1'b0, '0);
      add_row('{65536, -65536, 0, 0, 0, BIN_IDLE, BIN_IDLE, BIN_IDLE}, 1'b0, '0);
      add_row('{65537, -65537, 0, 0, 0, BIN_IDLE, BIN_IDLE, BIN_IDLE}, 1'b0, '0);
      add_row('{-1, 1, 105185, -1, 1, BIN_IDLE, BIN_IDLE, BIN_IDLE}, 1'b0, '0);
      add_row('1, 1'b0, '0);
      add_row('0, 1'b0, '0);
      add_row('{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                32'sh5555_5555, BIN_IDLE, qsm_pkg::BIN_LOW, qsm_pkg::BIN_HIGH}, 1'b0, '0);
      add_row('{0, 0, 3 * 65536, 8 * 65536, -8 * 65536, BIN_IDLE, qsm_pkg::BIN_HIGH,
                BIN_IDLE}, 1'b0, '0);
      add_row('{0, 0, -2 * 65536, 0, 0, BIN_IDLE, BIN_IDLE, qsm_pkg::BIN_LOW}, 1'b0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_tick(script[i].stim, script[i].typed, script[i].golden);
      end
      settle();
      random_ticks(100);

      // Rails: every setting at its ceiling, then at its floor
      program_settings('1, 32'h7FFF_FFFF, '1, '1, '1, '1, '1, '1);
      random_ticks(120);
      program_settings('0, 32'h8000_0000, '0, '0, '0, '0, '0, '0);
      random_ticks(100);

      repeat (4) begin
         program_settings(pick_word(), $urandom(), pick_word(), pick_word(),
                          pick_word(), pick_word(), pick_word(), pick_word());
         random_ticks(100);
      end
      repeat (2) begin
         program_plausible(32'($urandom_range(0, 65536)));
         random_ticks(120);
      end

      // Largest step the register holds: climb, then descend below the start
      program_plausible('1);
      ramp_target(1'b1, 40);
      ramp_target(1'b0, 60);
      random_ticks(20);

      repeat (12) @(posedge clock);
      if (faults == 0 && due_commands.size() == 0) begin
         $display("quadrotor_stabilizer_mixer regression: pass");
      end else begin
         $display("quadrotor_stabilizer_mixer regression: fail");
      end
      $finish;
   end

endmodule
